FILE: rtl/bvcl_pkg.sv
package bvcl_pkg;

    localparam int PinWidth         = 12;
    localparam int OhmWidth         = 16;
    localparam int ProductWidth     = 28;
    localparam int MvWidth          = 28;
    localparam int PointMvWidth     = 13;
    localparam int PctWidth         = 7;
    localparam int SegIdxWidth      = 4;
    localparam int SegmentCount     = 11;
    localparam int QueueDepth       = 4;
    localparam int QueuePtrWidth    = 2;
    localparam int DivStepsPerCycle = 4;
    localparam int DivCycles        = ProductWidth / DivStepsPerCycle;
    localparam int DivCountWidth    = 3;

    localparam logic [OhmWidth-1:0] DividerTopReset    = 16'd1000;
    localparam logic [OhmWidth-1:0] DividerBottomReset = 16'd510;

    // register select is address bit 2
    localparam logic RegDividerTop    = 1'b0;
    localparam logic RegDividerBottom = 1'b1;

    localparam logic [MvWidth-1:0] ChargeEmptyMv = 28'd3300;
    localparam logic [MvWidth-1:0] ChargeFullMv  = 28'd4200;
    localparam logic [7:0]         ChargeFull    = 8'd200;
    localparam logic [7:0]         ChargeEmpty   = 8'd0;

    // (mv + 50) / 100 by reciprocal, exact below 43699
    localparam logic [MvWidth-1:0] TenthsSatMv   = 28'd25550;
    localparam logic [14:0]        TenthsRound   = 15'd50;
    localparam logic [12:0]        TenthsRecip   = 13'd5243;
    localparam int                 TenthsShift   = 19;

    // m / 25 by reciprocal, exact for m up to 375
    localparam logic [5:0]         Recip25       = 6'd41;
    localparam int                 Recip25Shift  = 10;

    typedef struct packed {
        logic [ProductWidth-1:0] product;
        logic [PinWidth-1:0]     pin;
        logic [OhmWidth-1:0]     bottom;
        logic                    bottom_zero;
    } bvcl_job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_SUM,
        BK_SEGMENT,
        BK_INTERP,
        BK_FINISH
    } back_state_t;

    function automatic logic [PointMvWidth-1:0] point_mv(input logic [SegIdxWidth-1:0] k);
        unique case (k)
            4'd0:    point_mv = 13'd3300;
            4'd1:    point_mv = 13'd3500;
            4'd2:    point_mv = 13'd3600;
            4'd3:    point_mv = 13'd3650;
            4'd4:    point_mv = 13'd3700;
            4'd5:    point_mv = 13'd3750;
            4'd6:    point_mv = 13'd3800;
            4'd7:    point_mv = 13'd3850;
            4'd8:    point_mv = 13'd3900;
            4'd9:    point_mv = 13'd4000;
            4'd10:   point_mv = 13'd4100;
            4'd11:   point_mv = 13'd4200;
            default: point_mv = 13'd4200;
        endcase
    endfunction

    function automatic logic [PctWidth-1:0] point_pct(input logic [SegIdxWidth-1:0] k);
        unique case (k)
            4'd0:    point_pct = 7'd0;
            4'd1:    point_pct = 7'd5;
            4'd2:    point_pct = 7'd10;
            4'd3:    point_pct = 7'd15;
            4'd4:    point_pct = 7'd20;
            4'd5:    point_pct = 7'd30;
            4'd6:    point_pct = 7'd40;
            4'd7:    point_pct = 7'd50;
            4'd8:    point_pct = 7'd60;
            4'd9:    point_pct = 7'd75;
            4'd10:   point_pct = 7'd90;
            4'd11:   point_pct = 7'd100;
            default: point_pct = 7'd100;
        endcase
    endfunction

    // percent rise across a segment
    function automatic logic [3:0] seg_dpct(input logic [SegIdxWidth-1:0] s);
        unique case (s)
            4'd0, 4'd1, 4'd2, 4'd3: seg_dpct = 4'd5;
            4'd4, 4'd5, 4'd6, 4'd7: seg_dpct = 4'd10;
            4'd8, 4'd9:             seg_dpct = 4'd15;
            4'd10:                  seg_dpct = 4'd10;
            default:                seg_dpct = 4'd0;
        endcase
    endfunction

    // scale so every segment divides by 200: 200 mV wide -> 0, 100 -> 1, 50 -> 2
    function automatic logic [1:0] seg_shift(input logic [SegIdxWidth-1:0] s);
        unique case (s)
            4'd0:                                  seg_shift = 2'd0;
            4'd1, 4'd8, 4'd9, 4'd10:               seg_shift = 2'd1;
            4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7:    seg_shift = 2'd2;
            default:                               seg_shift = 2'd0;
        endcase
    endfunction

endpackage

FILE: rtl/battery_voltage_to_charge_level.sv
// Battery voltage to charge level. Each request carries one averaged ADC-pin voltage in mV;
// the block undoes the resistor divider (pin*top/bottom + pin) and returns battery mV,
// the voltage in 100 mV units and the charge in half-percent steps from a 12-point
// lithium-cell curve, each saturated to its field. The front side takes one request per
// cycle into a four-entry queue while the queue has room. The back side pops a request,
// forms the 28-bit quotient from the divider at 4 bits per cycle, then the sum, segment
// lookup, interpolation and result register (held while the output stalls), and only then
// pops the next. A zero bottom resistor skips divide and sum. Divider registers live at
// byte addresses 0 (top) and 4 (bottom) and should be written only while the block is idle.
module battery_voltage_to_charge_level
    import bvcl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] pin_millivolts, [15:12] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] battery_mv, [23:16] voltage_tenths,
                                   // [31:24] charge_half_percent
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [OhmWidth-1:0] divider_top_reg;
    logic [OhmWidth-1:0] divider_top_next;
    logic [OhmWidth-1:0] divider_bottom_reg;
    logic [OhmWidth-1:0] divider_bottom_next;
    logic                cfg_write;

    logic                push;
    logic                queue_ready;
    bvcl_job_t           front_job;
    logic                pop;
    logic                queue_valid;
    bvcl_job_t           back_job;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = {16'b0, (paddr[2] == RegDividerBottom) ? divider_bottom_reg
                                                              : divider_top_reg};

    always_comb
    begin
        divider_top_next    = divider_top_reg;
        divider_bottom_next = divider_bottom_reg;
        if (cfg_write)
        begin
            if (paddr[2] == RegDividerTop)
            begin
                divider_top_next = pwdata[OhmWidth-1:0];
            end
            else
            begin
                divider_bottom_next = pwdata[OhmWidth-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divider_top_reg    <= DividerTopReset;
            divider_bottom_reg <= DividerBottomReset;
        end
        else
        begin
            divider_top_reg    <= divider_top_next;
            divider_bottom_reg <= divider_bottom_next;
        end
    end

    bvcl_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .divider_top    (divider_top_reg),
        .divider_bottom (divider_bottom_reg),
        .push           (push),
        .queue_ready    (queue_ready),
        .job            (front_job)
    );

    bvcl_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .ready   (queue_ready),
        .job_in  (front_job),
        .pop     (pop),
        .valid   (queue_valid),
        .job_out (back_job)
    );

    bvcl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (queue_valid),
        .job       (back_job),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // the back end only takes work that is queued
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> queue_valid)
        else $error("pop from empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[31:24] <= ChargeFull))
        else $error("charge above full");

    // an unsaturated voltage at or below the empty point must read empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[15:0] <= 16'd3300)) |-> (m_tdata[31:24] == ChargeEmpty))
        else $error("charge not empty at low voltage");

    // a full queue holds off new requests once the front stage is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !queue_ready) |-> !s_tready)
        else $error("request accepted while front stage blocked");

endmodule

FILE: rtl/bvcl_front.sv
module bvcl_front
    import bvcl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,
    input  logic [OhmWidth-1:0] divider_top,
    input  logic [OhmWidth-1:0] divider_bottom,
    output logic                push,
    input  logic                queue_ready,
    output bvcl_job_t           job
);

    logic                    stage_valid_reg;
    logic                    stage_valid_next;
    logic [PinWidth-1:0]     stage_pin_reg;
    logic [ProductWidth-1:0] stage_product_reg;
    logic                    accept;

    assign s_tready = !stage_valid_reg || queue_ready;
    assign accept   = s_tvalid && s_tready;
    assign push     = stage_valid_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (queue_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_pin_reg     <= s_tdata[PinWidth-1:0];
            stage_product_reg <= {{(ProductWidth-PinWidth){1'b0}}, s_tdata[PinWidth-1:0]}
                               * {{(ProductWidth-OhmWidth){1'b0}}, divider_top};
        end
    end

    // divisor is sampled into the queue; the user must change it only while idle (unchecked)
    always_comb
    begin
        job.product     = stage_product_reg;
        job.pin         = stage_pin_reg;
        job.bottom      = divider_bottom;
        job.bottom_zero = (divider_bottom == '0);
    end

endmodule

FILE: rtl/bvcl_queue.sv
module bvcl_queue
    import bvcl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      ready,
    input  bvcl_job_t job_in,
    input  logic      pop,
    output logic      valid,
    output bvcl_job_t job_out
);

    bvcl_job_t                entries_reg [QueueDepth];
    logic [QueuePtrWidth-1:0] wr_ptr_reg;
    logic [QueuePtrWidth-1:0] wr_ptr_next;
    logic [QueuePtrWidth-1:0] rd_ptr_reg;
    logic [QueuePtrWidth-1:0] rd_ptr_next;
    logic [QueuePtrWidth:0]   count_reg;
    logic [QueuePtrWidth:0]   count_next;
    logic                     do_push;
    logic                     do_pop;

    assign ready   = (count_reg != (QueuePtrWidth+1)'(QueueDepth));
    assign valid   = (count_reg != '0);
    assign do_push = push && ready;
    assign do_pop  = pop && valid;
    assign job_out = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

FILE: rtl/bvcl_back.sv
module bvcl_back
    import bvcl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    input  bvcl_job_t   job,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata
);

    back_state_t              state_reg;
    back_state_t              state_next;
    logic [DivCountWidth-1:0] cnt_reg;
    logic [DivCountWidth-1:0] cnt_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     out_free;

    logic [ProductWidth-1:0]  n_reg;
    logic [OhmWidth-1:0]      r_reg;
    logic [OhmWidth-1:0]      div_reg;
    logic [PinWidth-1:0]      pin_reg;
    logic [MvWidth-1:0]       mv_reg;
    logic [15:0]              mvsat_reg;
    logic [7:0]               tenths_reg;
    logic                     low_reg;
    logic                     high_reg;
    logic [SegIdxWidth-1:0]   seg_reg;
    logic [7:0]               dlt_reg;
    logic [8:0]               m_reg;
    logic [15:0]              out_mv_reg;
    logic [7:0]               out_tenths_reg;
    logic [7:0]               out_charge_reg;

    logic [ProductWidth-1:0]  n_step;
    logic [OhmWidth-1:0]      r_step;
    logic [OhmWidth:0]        trial;

    logic [SegIdxWidth-1:0]   seg_sel;
    logic [PointMvWidth-1:0]  diff;
    logic [14:0]              tenths_x;
    logic [27:0]              tenths_prod;
    logic [7:0]               tenths_val;

    logic [13:0]              interp_n;
    logic [14:0]              q_prod;
    logic [PctWidth-1:0]      pct;
    logic [7:0]               charge_val;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_charge_reg, out_tenths_reg, out_mv_reg};

    // four restoring steps of the quotient per cycle
    always_comb
    begin
        r_step = r_reg;
        n_step = n_reg;
        trial  = '0;
        for (int i = 0; i < DivStepsPerCycle; i++)
        begin
            trial  = {r_step, n_step[ProductWidth-1]};
            n_step = {n_step[ProductWidth-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                trial     = trial - {1'b0, div_reg};
                n_step[0] = 1'b1;
            end
            r_step = trial[OhmWidth-1:0];
        end
    end

    // lowest segment whose upper point is at or above the voltage
    always_comb
    begin
        seg_sel = '0;
        for (int k = SegmentCount; k >= 1; k--)
        begin
            if (mv_reg <= MvWidth'(point_mv(SegIdxWidth'(k))))
            begin
                seg_sel = SegIdxWidth'(k - 1);
            end
        end
        diff        = mv_reg[PointMvWidth-1:0] - point_mv(seg_sel);
        tenths_x    = mv_reg[14:0] + TenthsRound;
        tenths_prod = {13'b0, tenths_x} * {15'b0, TenthsRecip};
        tenths_val  = (mv_reg >= TenthsSatMv) ? 8'hFF : tenths_prod[TenthsShift +: 8];
    end

    always_comb
    begin
        interp_n   = ({6'b0, dlt_reg} * {10'b0, seg_dpct(seg_reg)}) << seg_shift(seg_reg);
        q_prod     = {6'b0, m_reg} * {9'b0, Recip25};
        pct        = point_pct(seg_reg) + {2'b0, q_prod[Recip25Shift +: 5]};
        charge_val = {pct, 1'b0};
        if (low_reg)
        begin
            charge_val = ChargeEmpty;
        end
        else if (high_reg)
        begin
            charge_val = ChargeFull;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pop            = 1'b0;
        out_valid_next = m_tready ? 1'b0 : out_valid_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    pop        = 1'b1;
                    cnt_next   = '0;
                    state_next = job.bottom_zero ? BK_SEGMENT : BK_DIVIDE;
                end
            end
            BK_DIVIDE:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DivCountWidth'(DivCycles - 1))
                begin
                    state_next = BK_SUM;
                end
            end
            BK_SUM:     state_next = BK_SEGMENT;
            BK_SEGMENT: state_next = BK_INTERP;
            BK_INTERP:  state_next = BK_FINISH;
            BK_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = BK_IDLE;
                end
            end
            default:    state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    n_reg   <= job.product;
                    r_reg   <= '0;
                    div_reg <= job.bottom;
                    pin_reg <= job.pin;
                    // zero divisor skips the divide and saturates everything
                    mv_reg  <= '1;
                end
            end
            BK_DIVIDE:
            begin
                n_reg <= n_step;
                r_reg <= r_step;
            end
            BK_SUM:
            begin
                mv_reg <= n_reg + MvWidth'(pin_reg);
            end
            BK_SEGMENT:
            begin
                mvsat_reg  <= (mv_reg[MvWidth-1:16] != '0) ? 16'hFFFF : mv_reg[15:0];
                tenths_reg <= tenths_val;
                low_reg    <= (mv_reg <= ChargeEmptyMv);
                high_reg   <= (mv_reg >= ChargeFullMv);
                seg_reg    <= seg_sel;
                dlt_reg    <= diff[7:0];
            end
            BK_INTERP:
            begin
                m_reg <= interp_n[11:3];
            end
            BK_FINISH:
            begin
                if (out_free)
                begin
                    out_mv_reg     <= mvsat_reg;
                    out_tenths_reg <= tenths_reg;
                    out_charge_reg <= charge_val;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: test/battery_reading_checker.sv
`timescale 1ns / 1ps

module battery_reading_checker
    import bvcl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] pin_millivolts, [15:12] zero
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [15:0] battery_mv, [23:16] voltage_tenths,
                                   // [31:24] charge_half_percent
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          pending,
    output int          readings_checked
);

    typedef struct {
        logic [15:0] battery_mv;
        logic [7:0]  tenths;
        logic [7:0]  charge;
    } reading_t;

    reading_t            expected_readings[$];
    logic [OhmWidth-1:0] top_ohms;
    logic [OhmWidth-1:0] bottom_ohms;

    function automatic int unsigned curve_mv(input int k);
        case (k)
            0:       return 3300;
            1:       return 3500;
            2:       return 3600;
            3:       return 3650;
            4:       return 3700;
            5:       return 3750;
            6:       return 3800;
            7:       return 3850;
            8:       return 3900;
            9:       return 4000;
            10:      return 4100;
            default: return 4200;
        endcase
    endfunction

    function automatic int unsigned curve_pct(input int k);
        case (k)
            0:       return 0;
            1:       return 5;
            2:       return 10;
            3:       return 15;
            4:       return 20;
            5:       return 30;
            6:       return 40;
            7:       return 50;
            8:       return 60;
            9:       return 75;
            10:      return 90;
            default: return 100;
        endcase
    endfunction

    function automatic logic [7:0] charge_from_mv(input logic [31:0] mv);
        int unsigned pct;
        if (mv <= curve_mv(0))
            return ChargeEmpty;
        if (mv >= curve_mv(11))
            return ChargeFull;
        for (int k = 1; k < 12; k++)
        begin
            if (mv <= curve_mv(k))
            begin
                pct = curve_pct(k - 1) + ((mv - curve_mv(k - 1)) *
                      (curve_pct(k) - curve_pct(k - 1))) / (curve_mv(k) - curve_mv(k - 1));
                return 8'(pct * 2);
            end
        end
        return ChargeFull;
    endfunction

    function automatic reading_t predict_reading(input logic [11:0] pin,
                                                 input logic [15:0] top,
                                                 input logic [15:0] bottom);
        reading_t    r;
        logic [31:0] mv;
        logic [31:0] tenths;
        if (bottom == '0)
        begin
            // unbounded divider ratio, everything pinned at its ceiling
            r.battery_mv = 16'hFFFF;
            r.tenths     = 8'hFF;
            r.charge     = ChargeFull;
            return r;
        end
        mv     = (32'(pin) * 32'(top)) / 32'(bottom) + 32'(pin);
        tenths = (mv + 32'd50) / 32'd100;
        r.battery_mv = (mv > 32'd65535) ? 16'hFFFF : mv[15:0];
        r.tenths     = (tenths > 32'd255) ? 8'hFF : tenths[7:0];
        r.charge     = charge_from_mv(mv);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("mismatch at %0t, reading %0d, %s: expected %0d, got %0d",
                 $time, readings_checked, what, want, got);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        reading_t want;
        if (!rst_n)
        begin
            mismatches       = 0;
            readings_checked = 0;
            top_ohms         = DividerTopReset;
            bottom_ohms      = DividerBottomReset;
            expected_readings.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == RegDividerTop)
                    top_ohms = pwdata[OhmWidth-1:0];
                else
                    bottom_ohms = pwdata[OhmWidth-1:0];
            end
            if (s_tvalid && s_tready)
                expected_readings.push_back(
                    predict_reading(s_tdata[11:0], top_ohms, bottom_ohms));
            if (m_tvalid && m_tready)
            begin
                if (expected_readings.size() == 0)
                    report_mismatch("result with no request waiting", 0, m_tdata);
                else
                begin
                    want = expected_readings.pop_front();
                    if (m_tdata[15:0] !== want.battery_mv)
                        report_mismatch("battery_mv", want.battery_mv, m_tdata[15:0]);
                    if (m_tdata[23:16] !== want.tenths)
                        report_mismatch("voltage_tenths", want.tenths, m_tdata[23:16]);
                    if (m_tdata[31:24] !== want.charge)
                        report_mismatch("charge_half_percent", want.charge,
                                        m_tdata[31:24]);
                end
                readings_checked++;
            end
        end
        pending = expected_readings.size();
    end

endmodule

FILE: test/tb_battery_voltage_to_charge_level.sv
`timescale 1ns / 1ps

module tb_battery_voltage_to_charge_level
    import bvcl_pkg::*;
();

    localparam int IdleLimit     = 2000;
    localparam int ItemsPerSet   = 88;
    localparam int SettleCycles  = 16;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [11:0] pin_millivolts, [15:12] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [15:0] battery_mv, [23:16] voltage_tenths,
                            // [31:24] charge_half_percent
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          mismatches;
    int          pending;
    int          readings_checked;

    int          send_idle_pct;
    int          recv_stall_pct;
    int          idle_cycles;
    int          settings_used;
    logic [15:0] cur_top;
    logic [15:0] cur_bottom;

    battery_voltage_to_charge_level uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    battery_reading_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .mismatches       (mismatches),
        .pending          (pending),
        .readings_checked (readings_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // ends the run if neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IdleLimit)
            begin
                $display("timeout: no transfer for %0d cycles", IdleLimit);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_pin(input logic [11:0] pin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'h0, pin};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apb_write(input logic reg_sel, input logic [15:0] ohms);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        // upper data bits are junk, the register keeps only the low half
        pwdata  <= {16'($urandom), ohms};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_dividers(input logic [15:0] top, input logic [15:0] bottom);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
        apb_write(RegDividerTop, top);
        apb_write(RegDividerBottom, bottom);
        cur_top    = top;
        cur_bottom = bottom;
        settings_used++;
    endtask

    // most pins aimed so the battery lands on the discharge curve
    function automatic logic [11:0] random_pin();
        longint unsigned p;
        int unsigned     pick;
        pick = $urandom_range(99);
        if (pick < 70 && cur_bottom != 0)
        begin
            p = longint'($urandom_range(3250, 4250)) * cur_bottom /
                (longint'(cur_top) + cur_bottom);
            if (p <= 4095)
                return 12'(p);
        end
        else if (pick < 80)
            return $urandom_range(1) ? 12'hFFF : 12'h000;
        return 12'($urandom);
    endfunction

    initial
    begin
        logic [11:0] curve_pins[$];
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        settings_used  = 1;
        cur_top        = DividerTopReset;
        cur_bottom     = DividerBottomReset;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset divider values
        send_pin(12'd0);
        send_pin(12'd4095);
        send_pin(12'd1148);

        // zero top resistor: battery equals pin, around the empty point and at the pin maximum
        set_dividers(16'd0, 16'd510);
        send_pin(12'd3299);
        send_pin(12'd3300);
        send_pin(12'd3301);
        send_pin(12'd4095);

        // equal resistors double the pin, so every curve point is reachable
        curve_pins = '{1750, 1800, 1825, 1850, 1875, 1900, 1925, 1950,
                       2000, 2050, 2099, 2100};
        set_dividers(16'd1000, 16'd1000);
        foreach (curve_pins[i])
            send_pin(curve_pins[i]);

        // zero bottom resistor saturates every field
        set_dividers(16'd1000, 16'd0);
        send_pin(12'd0);
        send_pin(12'd4095);

        // largest ratio: pin 1 lands exactly one past the battery_mv ceiling
        set_dividers(16'd65535, 16'd1);
        send_pin(12'd1);
        send_pin(12'd4095);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            for (int set = 0; set < 5; set++)
            begin
                case (set)
                    0: set_dividers(DividerTopReset, DividerBottomReset);
                    1: set_dividers(16'd65535, 16'd65535);
                    2: set_dividers(16'd1, 16'd65535);
                    3:
                        case (phase)
                            1:       set_dividers(16'($urandom), 16'd0);
                            3:       set_dividers(16'd0, 16'($urandom_range(1, 65535)));
                            default: set_dividers(16'd65535, 16'd1);
                        endcase
                    default:
                    begin
                        cur_bottom = 16'($urandom_range(1, 65535));
                        if (phase[0])
                            cur_top = 16'($urandom);
                        else
                            cur_top = 16'((longint'(cur_bottom) * $urandom_range(0, 300) / 100)
                                          & 16'hFFFF);
                        set_dividers(cur_top, cur_bottom);
                    end
                endcase
                repeat (ItemsPerSet)
                    send_pin(random_pin());
            end
        end

        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SettleCycles) @(negedge clk);

        $display("checked %0d readings across %0d divider settings", readings_checked,
                 settings_used);
        $display("handshake mixes: free flowing, sparse requests, slow receiver, both");
        if (mismatches == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/bvcl_pkg.sv
rtl/bvcl_front.sv
rtl/bvcl_queue.sv
rtl/bvcl_back.sv
rtl/battery_voltage_to_charge_level.sv
test/battery_reading_checker.sv
test/tb_battery_voltage_to_charge_level.sv
